// ----- rtl/core/bpss_pkg.sv -----
// Shared types and constants for the balanced parenthesis span scanner.
// Used by the lexer, the result buffer and the top level; no dependencies.
package bpss_pkg;

  localparam int unsigned SpanW = 16;
  localparam int unsigned ByteW = 8;

  typedef struct packed {
    logic             found;
    logic [SpanW-1:0] span_length;
  } result_t;

  // Current input beat as seen by the lexer.
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             is_first;
    logic             is_last;
    logic [ByteW-1:0] ident_len;
  } in_beat_t;

endpackage

// ----- rtl/core/balanced_paren_span_scanner_top.sv -----
// Top level of the balanced parenthesis span scanner: input register and glue.
// Depends on bpss_pkg, bpss_lexer and bpss_out_buf.
//
//   Channel   Direction  tdata                          tuser      tlast
//   s_axis    in         [7:0] data_byte [15:8] ident   is_first   is_last
//   m_axis    out        [15:0] span_length             found      -
//
// One byte per cycle unless a result stalls: a beat waits in the input register,
// where the lexer steps it, and any result lands in the output register the next edge.
// The lexer state update, a loop through the lexer state registers, sets this rate.
// Reset clears all control state; no result is pending after it.
// A stalled result holds back the input register only for a beat that would
// produce another result; other bytes keep flowing.
module balanced_paren_span_scanner_top #(
  parameter int unsigned MAX_DEPTH = 255,
  parameter int unsigned MAX_SPAN  = 65535
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] data_byte, [15:8] ident_len
  input  logic        s_axis_tuser,   // [0] is_first
  input  logic        s_axis_tlast,   // is_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] span_length
  output logic        m_axis_tuser    // [0] found
);

  logic               in_valid_q, in_valid_d;
  bpss_pkg::in_beat_t in_beat_q, in_beat_d;
  logic               emit;
  logic               out_ready;
  logic               advance;
  bpss_pkg::result_t  step_result;
  bpss_pkg::result_t  out_result;

  assign advance       = in_valid_q && (!emit || out_ready);
  assign s_axis_tready = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    in_beat_d  = in_beat_q;
    if (advance) in_valid_d = 1'b0;
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d          = 1'b1;
      in_beat_d.data_byte = s_axis_tdata[7:0];
      in_beat_d.ident_len = s_axis_tdata[15:8];
      in_beat_d.is_first  = s_axis_tuser;
      in_beat_d.is_last   = s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_beat_q <= in_beat_d;
  end

  bpss_lexer #(
    .MAX_DEPTH(MAX_DEPTH),
    .MAX_SPAN (MAX_SPAN)
  ) u_lexer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .beat_i  (in_beat_q),
    .step_i  (advance),
    .emit_o  (emit),
    .result_o(step_result)
  );

  bpss_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance && emit),
    .result_i(step_result),
    .ready_o (out_ready),
    .valid_o (m_axis_tvalid),
    .take_i  (m_axis_tready),
    .result_o(out_result)
  );

  assign m_axis_tdata = out_result.span_length;
  assign m_axis_tuser = out_result.found;

endmodule

// ----- rtl/core/bpss_lexer.sv -----
// Lexer state, paren depth and length counters with the one-byte step logic.
// Depends on bpss_pkg for the beat and result types.
module bpss_lexer #(
  parameter int unsigned MAX_DEPTH = 255,
  parameter int unsigned MAX_SPAN  = 65535
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bpss_pkg::in_beat_t beat_i,
  input  logic               step_i,
  output logic               emit_o,
  output bpss_pkg::result_t  result_o
);

  localparam int unsigned DepthW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned CntW   = bpss_pkg::SpanW;
  localparam int unsigned TotW   = CntW + 1;
  localparam int unsigned SpanLimit = (MAX_SPAN < 65535) ? MAX_SPAN : 65535;
  localparam logic [TotW-1:0]   LimitV = TotW'(SpanLimit);
  localparam logic [DepthW-1:0] DepthMax = DepthW'(MAX_DEPTH);

  localparam logic [3:0] MIdle      = 4'd0;
  localparam logic [3:0] MWs        = 4'd1;
  localparam logic [3:0] MCode      = 4'd2;
  localparam logic [3:0] MSlash     = 4'd3;
  localparam logic [3:0] MStr       = 4'd4;
  localparam logic [3:0] MStrEsc    = 4'd5;
  localparam logic [3:0] MChr       = 4'd6;
  localparam logic [3:0] MChrEsc    = 4'd7;
  localparam logic [3:0] MLine      = 4'd8;
  localparam logic [3:0] MBlock     = 4'd9;
  localparam logic [3:0] MBlockStar = 4'd10;

  localparam logic [1:0] EvNone  = 2'd0;
  localparam logic [1:0] EvFound = 2'd1;
  localparam logic [1:0] EvFail  = 2'd2;

  localparam logic [7:0] ChOpen   = 8'h28;
  localparam logic [7:0] ChClose  = 8'h29;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;

  logic [3:0]        mode_q, mode_d;
  logic [DepthW-1:0] depth_q, depth_d;
  logic [CntW-1:0]   cons_q, cons_d;
  logic [7:0]        ident_q, ident_d;

  logic [3:0]        mode_v;
  logic [DepthW-1:0] depth_v;
  logic [CntW-1:0]   cons_v;
  logic [7:0]        ident_v;
  logic [7:0]        c;
  logic [TotW-1:0]   cons_inc;
  logic [TotW-1:0]   total;
  logic              is_ws;
  logic [3:0]        code_mode;
  logic [DepthW-1:0] code_depth;
  logic [1:0]        code_ev;
  logic [DepthW-1:0] dec_depth;
  logic [3:0]        nx_mode;
  logic [DepthW-1:0] nx_depth;
  logic [1:0]        ev;
  logic [1:0]        ev_fin;

  always_comb begin
    c       = beat_i.data_byte;
    mode_v  = beat_i.is_first ? MWs : mode_q;
    depth_v = beat_i.is_first ? '0 : depth_q;
    cons_v  = beat_i.is_first ? '0 : cons_q;
    ident_v = beat_i.is_first ? beat_i.ident_len : ident_q;
    cons_inc = {1'b0, cons_v} + TotW'(1);
    total    = cons_inc + TotW'(ident_v);
    is_ws    = (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));

    // Plain code context handling, shared by several modes.
    dec_depth  = (depth_v != '0) ? depth_v - DepthW'(1) : depth_v;
    code_depth = depth_v;
    code_ev    = EvNone;
    code_mode  = MCode;
    if (c == ChDquote) begin
      code_mode = MStr;
    end else if (c == ChSquote) begin
      code_mode = MChr;
    end else if (c == ChSlash) begin
      code_mode = MSlash;
    end else if (c == ChOpen) begin
      if (depth_v >= DepthMax) begin
        code_ev = EvFail;
      end else begin
        code_depth = depth_v + DepthW'(1);
      end
    end else if (c == ChClose) begin
      code_depth = dec_depth;
      if (dec_depth == '0) begin
        code_ev = EvFound;
      end
    end

    nx_mode  = mode_v;
    nx_depth = depth_v;
    ev       = EvNone;
    unique case (mode_v)
      MWs: begin
        if (!is_ws) begin
          if (c != ChOpen) begin
            ev = EvFail;
          end else begin
            nx_mode = code_mode; nx_depth = code_depth; ev = code_ev;
          end
        end
      end
      MCode: begin
        nx_mode = code_mode; nx_depth = code_depth; ev = code_ev;
      end
      MSlash: begin
        if (c == ChSlash) begin
          nx_mode = MLine;
        end else if (c == ChStar) begin
          nx_mode = MBlock;
        end else begin
          nx_mode = code_mode; nx_depth = code_depth; ev = code_ev;
        end
      end
      MStr: begin
        if (c == ChBslash) nx_mode = MStrEsc;
        else if (c == ChDquote) nx_mode = MCode;
      end
      MStrEsc: nx_mode = MStr;
      MChr: begin
        if (c == ChBslash) nx_mode = MChrEsc;
        else if (c == ChSquote) nx_mode = MCode;
      end
      MChrEsc: nx_mode = MChr;
      MLine: begin
        if (c == ChNl) nx_mode = MCode;
      end
      MBlock: begin
        if (c == ChStar) nx_mode = MBlockStar;
      end
      MBlockStar: begin
        if (c == ChSlash) nx_mode = MCode;
        else if (c != ChStar) nx_mode = MBlock;
      end
      default: ev = EvFail;
    endcase

    ev_fin = ev;
    if ((ev_fin != EvFail) && (total > LimitV)) ev_fin = EvFail;
    if ((ev_fin == EvNone) && beat_i.is_last) ev_fin = EvFail;

    emit_o               = (mode_v != MIdle) && (ev_fin != EvNone);
    result_o.found       = (ev_fin == EvFound);
    result_o.span_length = (ev_fin == EvFound) ? total[CntW-1:0] : '0;

    mode_d  = mode_q;
    depth_d = depth_q;
    cons_d  = cons_q;
    ident_d = ident_q;
    if (step_i) begin
      ident_d = ident_v;
      if (mode_v == MIdle) begin
        mode_d = mode_v;
      end else if (emit_o) begin
        mode_d  = MIdle;
        depth_d = '0;
        cons_d  = '0;
      end else begin
        mode_d  = nx_mode;
        depth_d = nx_depth;
        cons_d  = cons_inc[CntW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MIdle;
      depth_q <= '0;
      cons_q  <= '0;
      ident_q <= '0;
    end else begin
      mode_q  <= mode_d;
      depth_q <= depth_d;
      cons_q  <= cons_d;
      ident_q <= ident_d;
    end
  end

endmodule

// ----- rtl/core/bpss_out_buf.sv -----
// Result register on the master side of the scanner.
// Depends on bpss_pkg for the result type.
module bpss_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  bpss_pkg::result_t result_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              take_i,
  output bpss_pkg::result_t result_o
);

  logic              valid_q, valid_d;
  bpss_pkg::result_t data_q, data_d;

  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (take_i) valid_d = 1'b0;
    if (load_i) begin
      valid_d = 1'b1;
      data_d  = result_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o  = valid_q;
  assign result_o = data_q;

endmodule
